// ===== design/gaqr_pkg.sv =====
// gaqr_pkg: shared constants for the gravity-align quaternion rotation block.
// No dependencies; compiled first.
package gaqr_pkg;

    // default field and fraction widths
    localparam int SAMPLE_WIDTH   = 16;
    localparam int QUAT_FRAC_BITS = 15;

endpackage

// ===== design/gaqr_if.sv =====
// gaqr_if: valid/ready channel interfaces for samples in and rotated vectors out.
// Depends on gaqr_pkg for default widths.

// accelerometer sample channel
interface gaqr_in_if #(
    parameter int SW = gaqr_pkg::SAMPLE_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] accel_x;
    logic signed [SW-1:0] accel_y;
    logic signed [SW-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

// rotated vector channel
interface gaqr_out_if #(
    parameter int OW = gaqr_pkg::SAMPLE_WIDTH + 1
);
    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] rotated_x;
    logic signed [OW-1:0] rotated_y;
    logic signed [OW-1:0] rotated_z;

    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                    output ready);
endinterface

// ===== design/gravity_align_quaternion_rotate.sv =====
// Unlocked beats run through the serial square-root and divider units, one digit per cycle.
// Locked beats and zero samples skip those units; every beat uses the shared multiplier
// for 5 quaternion products and 9 matrix products.
// A beat is taken only in idle, after the last is done, but also while that result waits.
// Reset (rst_n, async low): quaternion = (2^F-1, 0, 0), hold_orientation = 0, no result.
// Depends on gaqr_pkg, gaqr_if, gaqr_isqrt, gaqr_div.
module gravity_align_quaternion_rotate #(
    parameter int SAMPLE_WIDTH   = gaqr_pkg::SAMPLE_WIDTH,
    parameter int QUAT_FRAC_BITS = gaqr_pkg::QUAT_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    gaqr_in_if.sink     accel,
    gaqr_out_if.source  rotated
);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int F   = QUAT_FRAC_BITS;
    localparam int OW  = SW + 1;
    localparam int QW  = F + 1;
    localparam int RW  = F + 3;
    localparam int MA  = (RW > SW + 1) ? RW : SW + 1;
    localparam int MB  = (SW + 1 > QW) ? SW + 1 : QW;
    localparam int PW  = MA + MB;
    localparam int ACW = PW + 2;
    localparam int XW  = (2 * SW > 2 * F + 2) ? 2 * SW : 2 * F + 2;
    localparam int HW  = XW / 2;
    localparam int DW  = SW + 2 * F;
    localparam int VW  = SW + 1;
    localparam int CQW = 2 * F + 1;
    localparam int PQW = 2 * F + 2;
    localparam int RPW = 2 * F + 4;

    localparam logic [HW:0]            QMAX_W = {{(HW - F + 1){1'b0}}, {F{1'b1}}};
    localparam logic signed [QW-1:0]   QMAX   = {1'b0, {F{1'b1}}};
    localparam logic signed [RPW-1:0]  ONE    = {3'b000, 1'b1, (2 * F)'(0)};
    localparam logic signed [RPW-1:0]  HALF_R = RPW'(1) << (F - 1);
    localparam logic signed [ACW-1:0]  HALF_O = ACW'(1) << (F - 1);
    localparam logic signed [ACW-1:0]  OMAX   = {{(ACW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
    localparam logic signed [ACW-1:0]  OMIN   = {{(ACW - OW + 1){1'b1}}, {(OW - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT_M, S_DIV_C, S_SQRT_C, S_DIV_S, S_SQRT_S, S_SQRT_G,
        S_MUL_X, S_DIV_X, S_MUL_Z, S_DIV_Z, S_QPROD, S_RMAT, S_ROT, S_DONE
    } state_t;

    // matrix entry: Q2F value rounded half up to QF
    function automatic logic signed [RW-1:0] round_q(input logic signed [RPW-1:0] v);
        logic signed [RPW-1:0] t;
        t = (v + HALF_R) >>> F;
        return t[RW-1:0];
    endfunction

    // output: QF sum rounded half up, clamped to OW bits
    function automatic logic signed [OW-1:0] round_sat(input logic signed [ACW-1:0] v);
        logic signed [ACW-1:0] t;
        t = (v + HALF_O) >>> F;
        if (t > OMAX)
            return OMAX[OW-1:0];
        else if (t < OMIN)
            return OMIN[OW-1:0];
        return t[OW-1:0];
    endfunction

    state_t                state_reg;
    logic                  hold_reg;
    logic [3:0]            step_reg;
    logic [1:0]            col_reg;
    logic [1:0]            row_reg;
    logic signed [SW-1:0]  ax_reg, ay_reg, az_reg;
    logic signed [ACW-1:0] acc_reg;
    logic [2*SW-1:0]       g2_reg;
    logic [SW-1:0]         m_reg;
    logic [SW-1:0]         g_reg;
    logic signed [QW-1:0]  q0_new_reg, q1_new_reg, s_reg;
    logic signed [QW-1:0]  q0_reg, q1_reg, q3_reg;
    logic signed [PQW-1:0] p01_reg, p03_reg, p11_reg, p13_reg, p33_reg;
    logic signed [RW-1:0]  r_reg [9];
    logic signed [OW-1:0]  res_reg [3];
    logic signed [OW-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic                  out_valid_reg;
    logic                  sq_start_reg, dv_start_reg;
    logic [XW-1:0]         sq_x_reg;
    logic [DW-1:0]         dv_n_reg;
    logic [VW-1:0]         dv_d_reg;

    logic                  sq_done, dv_done;
    logic [HW-1:0]         sq_root;
    logic [HW:0]           sq_rem;
    logic [DW-1:0]         dv_quot;

    logic signed [MA-1:0]  opa;
    logic signed [MB-1:0]  opb;
    logic signed [PW-1:0]  prod;
    logic signed [ACW-1:0] acc_sum;
    logic [2*SW-1:0]       a2;
    logic signed [SW:0]    abs_ax, abs_az;
    logic signed [SW+1:0]  m_minus_y, m_plus_y;
    logic [HW:0]           root_rnd;
    logic [F-1:0]          root_q;
    logic [PW-1:0]         prod_u;
    logic signed [QW-1:0]  quot_q;
    logic signed [RPW-1:0] p01_e, p03_e, p11_e, p13_e, p33_e;
    logic signed [SW-1:0]  col_sample;

    gaqr_isqrt #(.XW(XW)) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start_reg),
        .x     (sq_x_reg),
        .done  (sq_done),
        .root  (sq_root),
        .rem   (sq_rem)
    );

    gaqr_div #(.DW(DW), .VW(VW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start_reg),
        .dividend (dv_n_reg),
        .divisor  (dv_d_reg),
        .done     (dv_done),
        .quotient (dv_quot)
    );

    // operand helpers
    always_comb
    begin
        abs_ax    = (ax_reg < 0) ? -((SW + 1)'(ax_reg)) : (SW + 1)'(ax_reg);
        abs_az    = (az_reg < 0) ? -((SW + 1)'(az_reg)) : (SW + 1)'(az_reg);
        // M - ay taken straight from the root as it completes
        m_minus_y = $signed({2'b00, sq_root[SW-1:0]}) - (SW + 2)'(ay_reg);
        m_plus_y  = $signed({2'b00, m_reg}) + (SW + 2)'(ay_reg);
        acc_sum   = acc_reg + ACW'(prod);
        a2        = acc_sum[2*SW-1:0];
        prod_u    = prod;
        quot_q    = $signed(dv_quot[QW-1:0]);
        // rounded root, clamped to 2^F-1
        root_rnd  = (HW + 1)'(sq_root) + (HW + 1)'(sq_rem > {1'b0, sq_root});
        root_q    = (root_rnd > QMAX_W) ? QMAX_W[F-1:0] : root_rnd[F-1:0];
        p01_e     = RPW'(p01_reg);
        p03_e     = RPW'(p03_reg);
        p11_e     = RPW'(p11_reg);
        p13_e     = RPW'(p13_reg);
        p33_e     = RPW'(p33_reg);
        case (col_reg)
            2'd0:    col_sample = ax_reg;
            2'd1:    col_sample = ay_reg;
            default: col_sample = az_reg;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (state_reg)
            S_SQ:
            begin
                case (step_reg)
                    4'd0:    begin opa = MA'(ax_reg); opb = MB'(ax_reg); end
                    4'd1:    begin opa = MA'(az_reg); opb = MB'(az_reg); end
                    default: begin opa = MA'(ay_reg); opb = MB'(ay_reg); end
                endcase
            end
            S_MUL_X:
            begin
                opa = MA'(s_reg);
                opb = MB'(abs_az);
            end
            S_MUL_Z:
            begin
                opa = MA'(s_reg);
                opb = MB'(abs_ax);
            end
            S_QPROD:
            begin
                case (step_reg)
                    4'd0:    begin opa = MA'(q0_reg); opb = MB'(q1_reg); end
                    4'd1:    begin opa = MA'(q0_reg); opb = MB'(q3_reg); end
                    4'd2:    begin opa = MA'(q1_reg); opb = MB'(q1_reg); end
                    4'd3:    begin opa = MA'(q1_reg); opb = MB'(q3_reg); end
                    default: begin opa = MA'(q3_reg); opb = MB'(q3_reg); end
                endcase
            end
            S_ROT:
            begin
                opa = MA'(r_reg[step_reg]);
                opb = MB'(col_sample);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod = PW'(opa) * PW'(opb);

    // sequencer, quaternion store and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hold_reg      <= 1'b0;
            step_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            az_reg        <= '0;
            acc_reg       <= '0;
            g2_reg        <= '0;
            m_reg         <= '0;
            g_reg         <= '0;
            q0_new_reg    <= '0;
            q1_new_reg    <= '0;
            s_reg         <= '0;
            q0_reg        <= QMAX;
            q1_reg        <= '0;
            q3_reg        <= '0;
            p01_reg       <= '0;
            p03_reg       <= '0;
            p11_reg       <= '0;
            p13_reg       <= '0;
            p33_reg       <= '0;
            r_reg         <= '{default: '0};
            res_reg       <= '{default: '0};
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_valid_reg <= 1'b0;
            sq_start_reg  <= 1'b0;
            dv_start_reg  <= 1'b0;
            sq_x_reg      <= '0;
            dv_n_reg      <= '0;
            dv_d_reg      <= '0;
        end
        else
        begin
            sq_start_reg <= 1'b0;
            dv_start_reg <= 1'b0;

            if (cfg_write)
                hold_reg <= cfg_data;

            if (out_valid_reg && rotated.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                // take a beat
                S_IDLE:
                begin
                    if (accel.valid)
                    begin
                        ax_reg   <= accel.accel_x;
                        ay_reg   <= accel.accel_y;
                        az_reg   <= accel.accel_z;
                        step_reg <= '0;
                        state_reg <= hold_reg ? S_QPROD : S_SQ;
                    end
                end
                // |A|^2 and ax^2+az^2
                S_SQ:
                begin
                    acc_reg  <= (step_reg == 4'd0) ? ACW'(prod) : acc_sum;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd1)
                        g2_reg <= a2;
                    if (step_reg == 4'd2)
                    begin
                        step_reg <= '0;
                        if (a2 == '0)
                            state_reg <= S_QPROD;
                        else
                        begin
                            sq_x_reg     <= XW'(a2);
                            sq_start_reg <= 1'b1;
                            state_reg    <= S_SQRT_M;
                        end
                    end
                end
                // M done: C = (M-ay)*2^(2F-1)/M
                S_SQRT_M:
                begin
                    if (sq_done)
                    begin
                        m_reg        <= sq_root[SW-1:0];
                        state_reg    <= S_DIV_C;
                        dv_start_reg <= 1'b1;
                        dv_n_reg     <= {m_minus_y[SW:0], (2 * F - 1)'(0)};
                        dv_d_reg     <= VW'(sq_root[SW-1:0]);
                    end
                end
                S_DIV_C:
                begin
                    if (dv_done)
                    begin
                        sq_x_reg     <= XW'(dv_quot[CQW-1:0]);
                        sq_start_reg <= 1'b1;
                        state_reg    <= S_SQRT_C;
                    end
                end
                S_SQRT_C:
                begin
                    if (sq_done)
                    begin
                        q0_new_reg   <= {1'b0, root_q};
                        dv_n_reg     <= {m_plus_y[SW:0], (2 * F - 1)'(0)};
                        dv_d_reg     <= VW'(m_reg);
                        dv_start_reg <= 1'b1;
                        state_reg    <= S_DIV_S;
                    end
                end
                S_DIV_S:
                begin
                    if (dv_done)
                    begin
                        sq_x_reg     <= XW'(dv_quot[CQW-1:0]);
                        sq_start_reg <= 1'b1;
                        state_reg    <= S_SQRT_S;
                    end
                end
                S_SQRT_S:
                begin
                    if (sq_done)
                    begin
                        s_reg        <= {1'b0, root_q};
                        sq_x_reg     <= XW'(g2_reg);
                        sq_start_reg <= 1'b1;
                        state_reg    <= S_SQRT_G;
                    end
                end
                // axis length; pure y gravity gives a zero axis
                S_SQRT_G:
                begin
                    if (sq_done)
                    begin
                        g_reg <= sq_root[SW-1:0];
                        if (sq_root == '0)
                        begin
                            q0_reg    <= q0_new_reg;
                            q1_reg    <= '0;
                            q3_reg    <= '0;
                            step_reg  <= '0;
                            state_reg <= S_QPROD;
                        end
                        else
                            state_reg <= S_MUL_X;
                    end
                end
                // q1 = rdiv(s*az, G) as (2|s*az| + G) / 2G
                S_MUL_X:
                begin
                    dv_n_reg     <= DW'({prod_u, 1'b0}) + DW'(g_reg);
                    dv_d_reg     <= {g_reg, 1'b0};
                    dv_start_reg <= 1'b1;
                    state_reg    <= S_DIV_X;
                end
                S_DIV_X:
                begin
                    if (dv_done)
                    begin
                        q1_new_reg <= (az_reg < 0) ? -quot_q : quot_q;
                        state_reg  <= S_MUL_Z;
                    end
                end
                // q3 = rdiv(-s*ax, G)
                S_MUL_Z:
                begin
                    dv_n_reg     <= DW'({prod_u, 1'b0}) + DW'(g_reg);
                    dv_d_reg     <= {g_reg, 1'b0};
                    dv_start_reg <= 1'b1;
                    state_reg    <= S_DIV_Z;
                end
                S_DIV_Z:
                begin
                    if (dv_done)
                    begin
                        q0_reg    <= q0_new_reg;
                        q1_reg    <= q1_new_reg;
                        q3_reg    <= (ax_reg > 0) ? -quot_q : quot_q;
                        step_reg  <= '0;
                        state_reg <= S_QPROD;
                    end
                end
                // quaternion products, one per cycle
                S_QPROD:
                begin
                    case (step_reg)
                        4'd0:    p01_reg <= prod[PQW-1:0];
                        4'd1:    p03_reg <= prod[PQW-1:0];
                        4'd2:    p11_reg <= prod[PQW-1:0];
                        4'd3:    p13_reg <= prod[PQW-1:0];
                        default: p33_reg <= prod[PQW-1:0];
                    endcase
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd4)
                        state_reg <= S_RMAT;
                end
                // rotation matrix entries
                S_RMAT:
                begin
                    r_reg[0]  <= round_q(ONE - (p33_e <<< 1));
                    r_reg[1]  <= round_q(-(p03_e <<< 1));
                    r_reg[2]  <= round_q(p13_e <<< 1);
                    r_reg[3]  <= round_q(p03_e <<< 1);
                    r_reg[4]  <= round_q(ONE - ((p11_e + p33_e) <<< 1));
                    r_reg[5]  <= round_q(-(p01_e <<< 1));
                    r_reg[6]  <= round_q(p13_e <<< 1);
                    r_reg[7]  <= round_q(p01_e <<< 1);
                    r_reg[8]  <= round_q(ONE - (p11_e <<< 1));
                    step_reg  <= '0;
                    col_reg   <= '0;
                    row_reg   <= '0;
                    state_reg <= S_ROT;
                end
                // matrix times sample, one product per cycle
                S_ROT:
                begin
                    acc_reg  <= (col_reg == 2'd0) ? ACW'(prod) : acc_sum;
                    step_reg <= step_reg + 1'b1;
                    if (col_reg == 2'd2)
                    begin
                        res_reg[row_reg] <= round_sat(acc_sum);
                        col_reg          <= '0;
                        row_reg          <= row_reg + 1'b1;
                    end
                    else
                        col_reg <= col_reg + 1'b1;
                    if (step_reg == 4'd8)
                        state_reg <= S_DONE;
                end
                // hand result to the output register when it is free
                S_DONE:
                begin
                    if (!out_valid_reg || rotated.ready)
                    begin
                        out_x_reg     <= res_reg[0];
                        out_y_reg     <= res_reg[1];
                        out_z_reg     <= res_reg[2];
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign accel.ready       = (state_reg == S_IDLE);
    assign rotated.valid     = out_valid_reg;
    assign rotated.rotated_x = out_x_reg;
    assign rotated.rotated_y = out_y_reg;
    assign rotated.rotated_z = out_z_reg;

endmodule

// ===== design/gaqr_isqrt.sv =====
// gaqr_isqrt: digit-serial integer square root, two radicand bits per cycle.
// Gives floor root and remainder (x - root^2). No package dependencies.
module gaqr_isqrt #(
    parameter int XW = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [XW-1:0]     x,
    output logic              done,
    output logic [XW/2-1:0]   root,
    output logic [XW/2:0]     rem
);
    localparam int HW = XW / 2;
    localparam int CW = $clog2(HW) + 1;

    logic [XW-1:0]   x_reg;
    logic [HW:0]     rem_reg;
    logic [HW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [HW+2:0]   shifted;
    logic [HW+2:0]   trial;
    logic [HW+2:0]   diff;
    logic            fits;

    // one root digit: bring down two bits, try (root<<2)|1
    always_comb
    begin
        shifted = {rem_reg, x_reg[XW-1:XW-2]};
        trial   = {1'b0, root_reg, 2'b01};
        diff    = shifted - trial;
        fits    = (shifted >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= x;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                x_reg    <= {x_reg[XW-3:0], 2'b00};
                rem_reg  <= fits ? diff[HW:0] : shifted[HW:0];
                root_reg <= {root_reg[HW-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(HW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/gaqr_div.sv =====
// gaqr_div: bit-serial restoring divider, one quotient bit per cycle.
// Unsigned floor(dividend / divisor), divisor nonzero. No package dependencies.
module gaqr_div #(
    parameter int DW = 46,
    parameter int VW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW) + 1;

    logic [DW-1:0]  n_reg;
    logic [VW-1:0]  d_reg;
    logic [VW-1:0]  r_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [VW:0]    shifted;
    logic [VW:0]    diff;
    logic           fits;

    // shift in next dividend bit, subtract if it fits
    always_comb
    begin
        shifted = {r_reg, n_reg[DW-1]};
        diff    = shifted - {1'b0, d_reg};
        fits    = (shifted >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            d_reg    <= '0;
            r_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg    <= dividend;
                d_reg    <= divisor;
                r_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                n_reg   <= {n_reg[DW-2:0], fits};
                r_reg   <= fits ? diff[VW-1:0] : shifted[VW-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = n_reg;

endmodule

// ===== design/gaqr_checker.sv =====
// gaqr_checker: port-level assertions for the rotation block, bound to its top level.
// Depends on gravity_align_quaternion_rotate (bind target).
module gaqr_checker #(
    parameter int OW = gaqr_pkg::SAMPLE_WIDTH + 1
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [OW-1:0] rx,
    input logic [OW-1:0] ry,
    input logic [OW-1:0] rz
);
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    // beats taken in but not yet delivered
    always_comb
    begin
        pend_next = pend_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({rx, ry, rz}))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> pend_reg != 2'd0)
        else $error("result without a sample");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> pend_reg != 2'd2 && pend_reg != 2'd3)
        else $error("more than two beats in flight");

endmodule

bind gravity_align_quaternion_rotate gaqr_checker #(.OW(SAMPLE_WIDTH + 1)) u_gaqr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accel.valid),
    .in_ready  (accel.ready),
    .out_valid (rotated.valid),
    .out_ready (rotated.ready),
    .rx        (rotated.rotated_x),
    .ry        (rotated.rotated_y),
    .rz        (rotated.rotated_z)
);
